/* design/cor_pkg.sv */
// Shared types, constants and helpers for the circle octant rasterizer.
// Used by cor_front, cor_queue, cor_back and circle_octant_rasterizer.
`default_nettype none

package cor_pkg;

  // Default coordinate width of the centre and offset fields.
  localparam int unsigned COORD_BITS_DEF = 12;
  // Depth of the step queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  // Pixels emitted for one step (one per octant).
  localparam int unsigned PIX_PER_STEP = 8;
  localparam int unsigned PIX_IDX_BITS = $clog2(PIX_PER_STEP);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // Status of the front end, seen by the top level.
  typedef struct packed {
    logic active;     // a circle is in progress
    logic step_push;  // a step record enters the queue this cycle
  } front_status_t;

  // Per-octant mirror controls.
  typedef struct packed {
    logic swap;   // exchange x and y offsets
    logic neg_x;  // subtract the column offset
    logic neg_y;  // subtract the row offset
  } octant_t;

  function automatic octant_t octant_of(logic [PIX_IDX_BITS-1:0] idx);
    octant_t o;
    unique case (idx)
      3'd0:    o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      3'd1:    o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      3'd2:    o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      3'd3:    o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      3'd4:    o = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      3'd5:    o = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      3'd6:    o = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
      default: o = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

/* design/cor_front.sv */
// Front end: takes start and step words, keeps the circle state and
// produces one step record per active step. Depends on cor_pkg.
`default_nettype none

module cor_front import cor_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic                 op_i,
  input  wire logic [CoordBits-1:0] centre_x_i,
  input  wire logic [CoordBits-1:0] centre_y_i,
  input  wire logic [CoordBits-2:0] radius_i,
  output front_status_t             status_o,
  output logic      [4*CoordBits:0] rec_o
);

  localparam int unsigned DecBits = CoordBits + 4;
  localparam int unsigned CmpBits = CoordBits + 2;

  logic                 active_q, active_d;
  logic [CoordBits-1:0] cx_q, cy_q, x_q, y_q;
  logic [CoordBits-1:0] cx_d, cy_d, x_d, y_d;
  logic [DecBits-1:0]   dec_q, dec_d;

  logic               d_neg, step_go, start_go, done;
  logic [DecBits-1:0] x_ext, y_ext, inc_lo, inc_hi, dec_step, dec_start;
  logic [CmpBits-1:0] nx, ny;

  assign d_neg    = dec_q[DecBits-1];
  assign start_go = accept_i && (op_e'(op_i) == OP_START);
  assign step_go  = accept_i && (op_e'(op_i) == OP_STEP) && active_q;

  assign x_ext  = DecBits'(x_q);
  assign y_ext  = DecBits'(y_q);
  assign inc_lo = (x_ext << 2) + DecBits'(6);
  assign inc_hi = (x_ext << 2) - (y_ext << 2) + DecBits'(10);
  assign dec_step  = dec_q + (d_neg ? inc_lo : inc_hi);
  assign dec_start = DecBits'(3) - (DecBits'(radius_i) << 1);

  // y can reach -1 on a zero radius, so compare signed with headroom
  assign nx   = CmpBits'(x_q) + CmpBits'(1);
  assign ny   = CmpBits'(y_q) - (d_neg ? CmpBits'(0) : CmpBits'(1));
  assign done = $signed(nx) > $signed(ny);

  always_comb begin
    active_d = active_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    priority if (start_go) begin
      active_d = 1'b1;
      cx_d     = centre_x_i;
      cy_d     = centre_y_i;
      x_d      = '0;
      y_d      = CoordBits'(radius_i);
      dec_d    = dec_start;
    end else if (step_go) begin
      active_d = !done;
      x_d      = nx[CoordBits-1:0];
      y_d      = ny[CoordBits-1:0];
      dec_d    = dec_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    x_q   <= x_d;
    y_q   <= y_d;
    dec_q <= dec_d;
  end

  assign status_o.active    = active_q;
  assign status_o.step_push = step_go;
  assign rec_o = {cx_q, cy_q, x_q, y_q, done};

endmodule

`default_nettype wire

/* design/cor_queue.sv */
// Short register queue that decouples the front end from the pixel back end.
// Depends on cor_pkg for the default depth.
`default_nettype none

module cor_queue import cor_pkg::*; #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic      [Width-1:0] data_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;

  function automatic logic [PtrBits-1:0] ptr_next(logic [PtrBits-1:0] p);
    return (p == PtrBits'(Depth - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  assign full_o  = (cnt_q == CntBits'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* design/cor_back.sv */
// Back end: expands each step record into eight mirrored pixels, one per
// cycle into the output register while it is free. Depends on cor_pkg.
`default_nettype none

module cor_back import cor_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire logic        [4*CoordBits:0] q_data_i,
  output logic                             q_pop_o,
  input  wire logic                        pop,
  output logic                             empty,
  output logic signed      [CoordBits+1:0] pixel_x_o,
  output logic signed      [CoordBits+1:0] pixel_y_o,
  output logic                             last_of_step_o,
  output logic                             done_res_o
);

  localparam int unsigned PixBits = CoordBits + 2;

  logic                    busy_q, busy_d;
  logic [PIX_IDX_BITS-1:0] idx_q, idx_d;
  logic [CoordBits-1:0]    cx_q, cy_q, x_q, y_q;
  logic                    done_q;
  logic                    out_valid_q, out_valid_d;
  logic [PixBits-1:0]      px_q, py_q;
  logic                    last_q, out_done_q;

  logic               out_free, emit, step_end;
  octant_t            oct;
  logic [PixBits-1:0] ax, ay, cx_ext, cy_ext, px, py;

  assign out_free = !out_valid_q || pop;
  assign emit     = busy_q && out_free;
  assign step_end = emit && (idx_q == PIX_IDX_BITS'(PIX_PER_STEP - 1));
  assign q_pop_o  = !q_empty_i && (!busy_q || step_end);

  assign oct    = octant_of(idx_q);
  assign ax     = PixBits'(oct.swap ? y_q : x_q);
  assign ay     = PixBits'(oct.swap ? x_q : y_q);
  assign cx_ext = PixBits'(cx_q);
  assign cy_ext = PixBits'(cy_q);
  assign px     = oct.neg_x ? cx_ext - ax : cx_ext + ax;
  assign py     = oct.neg_y ? cy_ext - ay : cy_ext + ay;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    priority if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (step_end) begin
      busy_d = 1'b0;
      idx_d  = '0;
    end else if (emit) begin
      idx_d = idx_q + PIX_IDX_BITS'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      {cx_q, cy_q, x_q, y_q, done_q} <= q_data_i;
    end
    if (emit) begin
      px_q       <= px;
      py_q       <= py;
      last_q     <= (idx_q == PIX_IDX_BITS'(PIX_PER_STEP - 1));
      out_done_q <= done_q;
    end
  end

  assign empty          = !out_valid_q;
  assign pixel_x_o      = $signed(px_q);
  assign pixel_y_o      = $signed(py_q);
  assign last_of_step_o = last_q;
  assign done_res_o     = out_done_q;

endmodule

`default_nettype wire

/* design/circle_octant_rasterizer.sv */
// Midpoint circle rasterizer: top level joining front end, step queue and
// pixel back end. Depends on cor_pkg, cor_front, cor_queue and cor_back.
//
// Usage:
//   Input words are pushed with push while full is low. op = start loads
//   the centre and radius and emits nothing; op = step emits the eight
//   mirrored pixels of the current offsets, then advances the circle. A
//   step while no circle is running is dropped without output.
//   Pixels are read as a queue: while empty is low the oldest pixel sits on
//   the result ports and pop takes it. last_of_step marks the eighth pixel
//   of a step, done_res marks every pixel of the final step.
//   The first pixel of a step is visible once the step word has passed the
//   step queue, the back-end record register and the output register. One
//   pixel per cycle while pop keeps the output register free; the front
//   end takes one word per cycle until the two-entry step queue fills.
//   Reset clears the running flag, the queue and the output register.
//   When pop stays low the output register holds its pixel, the back end
//   stops, the queue fills and full rises.
`default_nettype none

module circle_octant_rasterizer import cor_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        op_i,
  input  wire logic        [CoordBits-1:0] centre_x_i,
  input  wire logic        [CoordBits-1:0] centre_y_i,
  input  wire logic        [CoordBits-2:0] radius_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic signed      [CoordBits+1:0] pixel_x_o,
  output logic signed      [CoordBits+1:0] pixel_y_o,
  output logic                             last_of_step_o,
  output logic                             done_res_o
);

  localparam int unsigned RecBits = 4 * CoordBits + 1;

  front_status_t      front_st;
  logic [RecBits-1:0] front_rec, q_rec;
  logic               q_full, q_empty, q_pop, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  cor_front #(
    .CoordBits(CoordBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_i),
    .centre_x_i(centre_x_i),
    .centre_y_i(centre_y_i),
    .radius_i  (radius_i),
    .status_o  (front_st),
    .rec_o     (front_rec)
  );

  cor_queue #(
    .Width(RecBits),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_st.step_push),
    .data_i (front_rec),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .data_o (q_rec)
  );

  cor_back #(
    .CoordBits(CoordBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rec),
    .q_pop_o       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_of_step_o(last_of_step_o),
    .done_res_o    (done_res_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.step_push |-> !q_full)
    else $error("step record pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end took a record from an empty queue");

  a_done_ends_circle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_st.step_push && front_rec[0] && !(push && !q_full && (op_i == OP_START)))
      |=> !front_st.active)
    else $error("circle still running after its final step");

endmodule

`default_nettype wire
